@@ src/exs_pkg.sv @@
`default_nettype none

package exs_pkg;

   localparam int MaxRanks = 256;
   localparam int ReduceCells = 2;

   localparam logic [1:0] ALG_ONE_FACTOR = 2'd0;
   localparam logic [1:0] ALG_HYPERCUBE  = 2'd1;
   localparam logic [1:0] ALG_HANDSHAKE  = 2'd2;

   localparam logic [1:0] CSR_NUM_RANKS = 2'd0;
   localparam logic [1:0] CSR_ALGORITHM = 2'd1;

   typedef struct packed {
      logic [9:0] a;
      logic [9:0] b;
      logic [8:0] modulus;
      logic       error;
   } lane_type;

endpackage

`default_nettype wire

@@ src/exs_req_if.sv @@
`default_nettype none

interface exs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] round_index;
   logic [7:0] slot_index;

   modport source (output valid, output round_index, output slot_index, input ready);
   modport sink (input valid, input round_index, input slot_index, output ready);
endinterface

`default_nettype wire

@@ src/exs_rsp_if.sv @@
`default_nettype none

interface exs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] first_rank;
   logic [7:0] second_rank;
   logic       error;

   modport source (output valid, output first_rank, output second_rank, output error,
                   input ready);
   modport sink (input valid, input first_rank, input second_rank, input error,
                 output ready);
endinterface

`default_nettype wire

@@ src/exs_prep.sv @@
`default_nettype none

module exs_prep (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [8:0]        num_ranks,
   input  wire logic [1:0]        algorithm,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire logic [7:0]        round_index,
   input  wire logic [7:0]        slot_index,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output exs_pkg::lane_type      out_data
);

   logic              valid_ff;
   exs_pkg::lane_type data_ff;
   exs_pkg::lane_type data_in;

   logic [8:0] n9;
   logic [8:0] m9;
   logic [8:0] k9;
   logic [8:0] s9;
   logic [8:0] r9;
   logic [9:0] idle_sum;
   logic [8:0] idle9;
   logic       bad;

   assign n9 = num_ranks;
   assign m9 = num_ranks - 9'd1;
   assign k9 = {1'b0, round_index};
   assign s9 = {1'b0, slot_index};
   assign r9 = k9 - 9'd1;
   assign idle_sum = {1'b0, r9} + (r9[0] ? {1'b0, m9} : 10'd0);
   assign idle9 = idle_sum[9:1];

   assign bad = (n9 == 9'd0) || (n9 > 9'(exs_pkg::MaxRanks))
             || (algorithm > exs_pkg::ALG_HANDSHAKE)
             || (k9 >= n9) || (s9 >= n9)
             || ((algorithm == exs_pkg::ALG_HYPERCUBE) && ((n9 & m9) != 9'd0));

   always_comb begin
      data_in.a = 10'd0;
      data_in.b = 10'd0;
      data_in.modulus = n9;
      data_in.error = 1'b1;
      if (!bad) begin
         data_in.error = 1'b0;
         if ((algorithm == exs_pkg::ALG_ONE_FACTOR) && n9[0]) begin
            data_in.a = {1'b0, s9};
            data_in.b = {1'b0, k9} + 10'd1 + {1'b0, n9} - {1'b0, s9};
         end else if (k9 == 9'd0) begin
            data_in.a = {1'b0, s9};
            data_in.b = {1'b0, s9};
         end else begin
            case (algorithm)
               exs_pkg::ALG_ONE_FACTOR: begin
                  if (s9 == m9) begin
                     data_in.a = {1'b0, m9};
                     data_in.b = {1'b0, idle9};
                  end else if (s9 == idle9) begin
                     data_in.a = {1'b0, idle9};
                     data_in.b = {1'b0, m9};
                  end else begin
                     data_in.a = {1'b0, s9};
                     data_in.b = {1'b0, r9} + {1'b0, m9} - {1'b0, s9};
                     data_in.modulus = m9;
                  end
               end
               exs_pkg::ALG_HYPERCUBE: begin
                  data_in.a = {1'b0, s9};
                  data_in.b = {1'b0, s9 ^ k9};
               end
               default: begin
                  data_in.a = {1'b0, s9} + {1'b0, k9};
                  data_in.b = {1'b0, s9} + {1'b0, n9} - {1'b0, k9};
               end
            endcase
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

@@ src/exs_cell.sv @@
`default_nettype none

module exs_cell (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire exs_pkg::lane_type in_data,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output exs_pkg::lane_type      out_data
);

   logic              valid_ff;
   exs_pkg::lane_type data_ff;
   exs_pkg::lane_type data_in;

   always_comb begin
      data_in = in_data;
      if (in_data.a >= {1'b0, in_data.modulus}) begin
         data_in.a = in_data.a - {1'b0, in_data.modulus};
      end
      if (in_data.b >= {1'b0, in_data.modulus}) begin
         data_in.b = in_data.b - {1'b0, in_data.modulus};
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

@@ src/exchange_schedule_partner_calc_unit.sv @@
// Exchange schedule partner lookup.
// req_bus carries a word of round_index and slot_index; rsp_bus returns one word of
// first_rank, second_rank and error for every request word, in order.
// csr_write with csr_index 0 sets num_ranks, index 1 sets algorithm (0 one-factor,
// 1 hypercube, 2 flat handshake); other indexes are dropped. Write only while idle.
// A request passes a front stage that selects the raw pair and the modulus, then
// a row of two reduce cells, each taking one conditional subtract off both ranks.
// Three register stages (front stage, then each reduce cell) lead to rsp_bus; one word
// per cycle is taken and returned when the receiver keeps ready high.
// Reset clears the pipeline and sets num_ranks to 1 and algorithm to 0.
// When rsp_bus stalls, every stage holds its word; req_bus.ready falls once all
// three stages are full, and a word is never lost or repeated.
// Out-of-range round or slot, bad rank count or algorithm, or hypercube on a
// rank count that is not a power of two returns error with zero ranks.
`default_nettype none

module exchange_schedule_partner_calc_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   exs_req_if.sink         req_bus,
   exs_rsp_if.source       rsp_bus,
   input  wire logic       csr_write,
   input  wire logic [1:0] csr_index,
   input  wire logic [8:0] csr_data
);

   localparam int Cells = exs_pkg::ReduceCells;

   logic [8:0] num_ranks_ff;
   logic [1:0] algorithm_ff;

   logic              chain_valid [Cells+1];
   logic              chain_ready [Cells+1];
   exs_pkg::lane_type chain_data  [Cells+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ranks_ff <= 9'd1;
         algorithm_ff <= exs_pkg::ALG_ONE_FACTOR;
      end else if (csr_write) begin
         if (csr_index == exs_pkg::CSR_NUM_RANKS) begin
            num_ranks_ff <= csr_data;
         end else if (csr_index == exs_pkg::CSR_ALGORITHM) begin
            algorithm_ff <= csr_data[1:0];
         end
      end
   end

   exs_prep u_prep (
      .clock       (clock),
      .reset       (reset),
      .num_ranks   (num_ranks_ff),
      .algorithm   (algorithm_ff),
      .in_valid    (req_bus.valid),
      .in_ready    (req_bus.ready),
      .round_index (req_bus.round_index),
      .slot_index  (req_bus.slot_index),
      .out_valid   (chain_valid[0]),
      .out_ready   (chain_ready[0]),
      .out_data    (chain_data[0])
   );

   for (genvar i = 0; i < Cells; i++) begin : g_cell
      exs_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_data   (chain_data[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_data  (chain_data[i+1])
      );
   end

   assign rsp_bus.valid = chain_valid[Cells];
   assign chain_ready[Cells] = rsp_bus.ready;
   assign rsp_bus.first_rank = chain_data[Cells].a[7:0];
   assign rsp_bus.second_rank = chain_data[Cells].b[7:0];
   assign rsp_bus.error = chain_data[Cells].error;

   a_reduced: assert property (@(posedge clock) disable iff (reset)
      chain_valid[Cells] && !chain_data[Cells].error |->
         (chain_data[Cells].a < {1'b0, chain_data[Cells].modulus})
         && (chain_data[Cells].b < {1'b0, chain_data[Cells].modulus}))
      else $error("response rank not reduced below modulus");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.error |->
         (rsp_bus.first_rank == 8'd0) && (rsp_bus.second_rank == 8'd0))
      else $error("error response carries nonzero ranks");

   a_front_stall: assert property (@(posedge clock) disable iff (reset)
      chain_valid[0] && !chain_ready[0] |=> chain_valid[0])
      else $error("front stage dropped a held word");

endmodule

`default_nettype wire
